### hdl/cra_pkg.sv
package cra_pkg;

    // default table geometry
    localparam int TABLE_ENTRIES = 32;
    localparam int HW_FILTERS    = 14;

    // field widths
    localparam int ID_W    = 11;
    localparam int IDX_W   = 5;
    localparam int SIZE_W  = 6;
    localparam int HWIDX_W = 8;
    localparam int DLC_W   = 4;
    localparam int DATA_W  = 64;
    localparam int WORD_W  = 32;
    // wide enough for any table size and for the hardware index
    localparam int CNT_W   = 9;

    localparam logic [SIZE_W-1:0] RX_SIZE_RESET = SIZE_W'(32);
    localparam int                ID_SHIFT      = 21;
    localparam logic [WORD_W-1:0] MASK_RESET    = 32'h0000_FFFF;
    localparam logic [WORD_W-1:0] BIT_RTR       = 32'h0000_0002;
    localparam logic [WORD_W-1:0] BIT_IDE       = 32'h0000_0004;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ILLEGAL  = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_NOMATCH  = 2'd3
    } t_status;

    typedef enum logic {
        OP_CONFIG = 1'b0,
        OP_FRAME  = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        RES_OK,
        RES_ILLEGAL,
        RES_OVERRUN,
        RES_NOMATCH,
        RES_DELIVER
    } t_res;

    // stored part of a filter entry, the fixed bits are rebuilt on read
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] mask;
        logic            rtr;
    } t_ent;

    typedef struct packed {
        logic load;
        logic cfg_wr;
        logic idx_init;
        logic idx_step;
        logic rd;
        logic res_load;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic is_cfg;
        logic cfg_ok;
        logic overrun;
        logic hw_mode;
        logic hw_ok;
        logic hit;
        logic hit_cfg;
        logic last;
        logic out_free;
    } t_sts;

    // masked compare of a frame word against one entry; an unwritten
    // entry acts as its reset contents
    function automatic logic entry_hit(logic [WORD_W-1:0] word, t_ent e, logic vld);
        logic [WORD_W-1:0] ident;
        logic [WORD_W-1:0] mask;
        if (vld) begin
            ident = (WORD_W'(e.id) << ID_SHIFT) | (e.rtr ? BIT_RTR : '0);
            mask  = (WORD_W'(e.mask) << ID_SHIFT) | BIT_RTR | BIT_IDE;
        end else begin
            ident = '0;
            mask  = MASK_RESET;
        end
        return ((word ^ ident) & mask) == '0;
    endfunction

endpackage

### hdl/cra_ctrl.sv
module cra_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cra_pkg::t_sts i_sts,
    output cra_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.is_cfg) begin
                    if (i_sts.out_free) begin
                        o_cmd.cfg_wr   = i_sts.cfg_ok;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res      = i_sts.cfg_ok ? cra_pkg::RES_OK : cra_pkg::RES_ILLEGAL;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.overrun) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res      = cra_pkg::RES_OVERRUN;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.hw_mode && !i_sts.hw_ok) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res      = cra_pkg::RES_NOMATCH;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_init = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res      = i_sts.hit_cfg ? cra_pkg::RES_DELIVER
                                                       : cra_pkg::RES_NOMATCH;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.hw_mode || i_sts.last) begin
                    if (i_sts.out_free) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res      = cra_pkg::RES_NOMATCH;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_step = 1'b1;
                    n_state        = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/cra_datapath.sv
module cra_datapath #(
    parameter int TABLE_ENTRIES = cra_pkg::TABLE_ENTRIES,
    parameter int HW_FILTERS    = cra_pkg::HW_FILTERS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [cra_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_opcode,
    input  logic [cra_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [cra_pkg::ID_W-1:0]     i_entry_ident,
    input  logic [cra_pkg::ID_W-1:0]     i_entry_mask,
    input  logic                         i_entry_rtr,
    input  logic [cra_pkg::WORD_W-1:0]   i_frame_word,
    input  logic [cra_pkg::DLC_W-1:0]    i_frame_dlc,
    input  logic [cra_pkg::DATA_W-1:0]   i_frame_data,
    input  logic [cra_pkg::HWIDX_W-1:0]  i_hw_filter_index,
    input  logic                         i_rx_overrun,
    input  cra_pkg::t_cmd                i_cmd,
    output cra_pkg::t_sts                o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_delivered,
    output logic [cra_pkg::IDX_W-1:0]    o_matched_entry,
    output logic [cra_pkg::DLC_W-1:0]    o_out_dlc,
    output logic [cra_pkg::DATA_W-1:0]   o_out_data
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = cra_pkg::CNT_W;

    // size register
    logic [cra_pkg::SIZE_W-1:0] r_rx_size;

    // captured item
    logic                         r_opcode;
    logic [cra_pkg::IDX_W-1:0]    r_eidx;
    logic [cra_pkg::ID_W-1:0]     r_eid;
    logic [cra_pkg::ID_W-1:0]     r_emask;
    logic                         r_ertr;
    logic [cra_pkg::WORD_W-1:0]   r_word;
    logic [cra_pkg::DLC_W-1:0]    r_dlc;
    logic [cra_pkg::DATA_W-1:0]   r_data;
    logic [cra_pkg::HWIDX_W-1:0]  r_hwidx;
    logic                         r_ovr;

    // filter table and its written flags
    cra_pkg::t_ent              r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   r_vld;
    cra_pkg::t_ent              r_rd_ent;
    logic                       r_rd_vld;
    logic [IW-1:0]              r_idx;

    // result register
    logic                         r_out_valid;
    cra_pkg::t_status             r_status;
    logic                         r_delivered;
    logic [cra_pkg::IDX_W-1:0]    r_matched;
    logic [cra_pkg::DLC_W-1:0]    r_out_dlc;
    logic [cra_pkg::DATA_W-1:0]   r_out_data;

    logic [CW-1:0]  act_size;
    logic [CW-1:0]  eidx_w;
    logic [CW-1:0]  hwidx_w;
    logic [CW-1:0]  idx_w;
    logic [IW-1:0]  waddr;
    logic [IW-1:0]  hwaddr;
    logic           res_deliver;

    assign act_size = (CW'(r_rx_size) > CW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES)
                                                           : CW'(r_rx_size);
    assign eidx_w   = CW'(r_eidx);
    assign hwidx_w  = CW'(r_hwidx);
    assign idx_w    = CW'(r_idx);
    assign waddr    = eidx_w[IW-1:0];
    assign hwaddr   = hwidx_w[IW-1:0];

    assign res_deliver = (i_cmd.res == cra_pkg::RES_DELIVER);

    always_comb begin
        o_sts.is_cfg   = (r_opcode == cra_pkg::OP_CONFIG);
        o_sts.cfg_ok   = (eidx_w < act_size);
        o_sts.overrun  = r_ovr;
        o_sts.hw_mode  = (act_size <= CW'(HW_FILTERS));
        o_sts.hw_ok    = (hwidx_w < act_size);
        o_sts.hit      = cra_pkg::entry_hit(r_word, r_rd_ent, r_rd_vld);
        o_sts.hit_cfg  = r_rd_vld;
        o_sts.last     = ((idx_w + CW'(1)) >= act_size);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_size   <= cra_pkg::RX_SIZE_RESET;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rx_size <= i_cfg_wr_data;
            end
            if (i_cmd.cfg_wr) begin
                r_vld[waddr] <= 1'b1;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_eidx   <= i_entry_index;
            r_eid    <= i_entry_ident;
            r_emask  <= i_entry_mask;
            r_ertr   <= i_entry_rtr;
            r_word   <= i_frame_word;
            r_dlc    <= i_frame_dlc;
            r_data   <= i_frame_data;
            r_hwidx  <= i_hw_filter_index;
            r_ovr    <= i_rx_overrun;
        end
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.cfg_wr) begin
            r_mem[waddr] <= '{id: r_eid, mask: r_emask, rtr: r_ertr};
        end
        if (i_cmd.rd) begin
            r_rd_ent <= r_mem[r_idx];
            r_rd_vld <= r_vld[r_idx];
        end
    end

    // entry pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_init) begin
            r_idx <= o_sts.hw_mode ? hwaddr : '0;
        end else if (i_cmd.idx_step) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // result status and payload, the payload zero unless the frame is delivered
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            unique case (i_cmd.res)
                cra_pkg::RES_OK:      r_status <= cra_pkg::ST_OK;
                cra_pkg::RES_ILLEGAL: r_status <= cra_pkg::ST_ILLEGAL;
                cra_pkg::RES_OVERRUN: r_status <= cra_pkg::ST_OVERRUN;
                cra_pkg::RES_DELIVER: r_status <= cra_pkg::ST_OK;
                default:              r_status <= cra_pkg::ST_NOMATCH;
            endcase
            r_delivered <= res_deliver;
            r_matched   <= res_deliver ? idx_w[cra_pkg::IDX_W-1:0] : '0;
            r_out_dlc   <= res_deliver ? r_dlc : '0;
            r_out_data  <= res_deliver ? r_data : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_delivered     = r_delivered;
    assign o_matched_entry = r_matched;
    assign o_out_dlc       = r_out_dlc;
    assign o_out_data      = r_out_data;

endmodule

### hdl/can_rx_acceptance_filter_unit.sv
// can receive acceptance filter for 11-bit standard identifiers. a configure
// beat (opcode 0) programs filter entry entry_index with identifier, compare
// mask and rtr expectation, answered with status ok or illegal argument when
// the index is not below the active size (min of rx_size and TABLE_ENTRIES).
// a frame beat (opcode 1) is dropped with status overrun if rx_overrun is set;
// otherwise, when the active size is at most HW_FILTERS only the entry at
// hw_filter_index is checked, else entries are searched from 0 upward and the
// first masked match decides. the frame is delivered (delivered=1, dlc and
// data passed on) only if that entry has been configured; every other result
// has status no-match and zeroed payload. one result beat per input beat.
// configure and overrun beats, and a hardware-index frame whose index is not
// below the active size, are answered without a table read; any other frame
// reads and then compares one entry at a time (its one hardware-index entry,
// or up to the active size when searched), since the table memory has a
// single registered read port. evaluation waits while an earlier result is
// still held in the output register; that register lets the next beat be
// taken while a result waits. unwritten entries behave as their reset
// contents (ident 0, mask 0xffff) through per-entry written flags, so there
// is no clearing pass after reset. rx_size never alters entries. the user
// must write rx_size only while the block is idle; this is not enforced.
module can_rx_acceptance_filter_unit #(
    parameter int TABLE_ENTRIES = cra_pkg::TABLE_ENTRIES,
    parameter int HW_FILTERS    = cra_pkg::HW_FILTERS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // rx_size register write
    input  logic                         i_cfg_wr_en,
    input  logic [cra_pkg::SIZE_W-1:0]   i_cfg_wr_data,
    // input beat
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_opcode,
    input  logic [cra_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [cra_pkg::ID_W-1:0]     i_entry_ident,
    input  logic [cra_pkg::ID_W-1:0]     i_entry_mask,
    input  logic                         i_entry_rtr,
    input  logic [cra_pkg::WORD_W-1:0]   i_frame_word,
    input  logic [cra_pkg::DLC_W-1:0]    i_frame_dlc,
    input  logic [cra_pkg::DATA_W-1:0]   i_frame_data,
    input  logic [cra_pkg::HWIDX_W-1:0]  i_hw_filter_index,
    input  logic                         i_rx_overrun,
    // result beat
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_delivered,
    output logic [cra_pkg::IDX_W-1:0]    o_matched_entry,
    output logic [cra_pkg::DLC_W-1:0]    o_out_dlc,
    output logic [cra_pkg::DATA_W-1:0]   o_out_data
);

    cra_pkg::t_cmd cmd;
    cra_pkg::t_sts sts;

    // sequencer: capture, evaluate, then read/compare entries one at a time
    cra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // item registers, filter table, compare and result register
    cra_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .HW_FILTERS    (HW_FILTERS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_opcode          (i_opcode),
        .i_entry_index     (i_entry_index),
        .i_entry_ident     (i_entry_ident),
        .i_entry_mask      (i_entry_mask),
        .i_entry_rtr       (i_entry_rtr),
        .i_frame_word      (i_frame_word),
        .i_frame_dlc       (i_frame_dlc),
        .i_frame_data      (i_frame_data),
        .i_hw_filter_index (i_hw_filter_index),
        .i_rx_overrun      (i_rx_overrun),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_delivered       (o_delivered),
        .o_matched_entry   (o_matched_entry),
        .o_out_dlc         (o_out_dlc),
        .o_out_data        (o_out_data)
    );

`ifndef ASSERT_OFF
    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten");

    // a delivery always reports status ok
    a_deliver_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_delivered) |-> (o_status == cra_pkg::ST_OK))
        else $error("delivery with bad status");

    // results that are not deliveries carry a zeroed payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_delivered) |->
            (o_matched_entry == '0 && o_out_dlc == '0 && o_out_data == '0))
        else $error("payload not cleared");

    // after taking a beat the block is not ready again in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted beats back to back");
`endif

endmodule

### dv/testbench.sv
// one input beat, every field as the block sees it
typedef struct {
    cra_pkg::t_opcode            op;
    logic [cra_pkg::IDX_W-1:0]   index;
    logic [cra_pkg::ID_W-1:0]    ident;
    logic [cra_pkg::ID_W-1:0]    mask;
    logic                        rtr;
    logic [cra_pkg::WORD_W-1:0]  word;
    logic [cra_pkg::DLC_W-1:0]   dlc;
    logic [cra_pkg::DATA_W-1:0]  data;
    logic [cra_pkg::HWIDX_W-1:0] hw_idx;
    logic                        overrun;
} t_rx_beat;

typedef struct {
    cra_pkg::t_status           status;
    logic                       delivered;
    logic [cra_pkg::IDX_W-1:0]  entry;
    logic [cra_pkg::DLC_W-1:0]  dlc;
    logic [cra_pkg::DATA_W-1:0] data;
} t_rx_result;

// shadow copy of the filter table plus the results still owed by the block
class rx_filter_shadow;
    logic [cra_pkg::WORD_W-1:0] ident_tab[cra_pkg::TABLE_ENTRIES];
    logic [cra_pkg::WORD_W-1:0] mask_tab[cra_pkg::TABLE_ENTRIES];
    bit                         used_tab[cra_pkg::TABLE_ENTRIES];
    logic [cra_pkg::SIZE_W-1:0] size_reg;
    t_rx_result                 pending_results[$];
    int                         errors;

    function new();
        foreach (ident_tab[k]) begin
            ident_tab[k] = '0;
            mask_tab[k]  = cra_pkg::MASK_RESET;
            used_tab[k]  = 1'b0;
        end
        size_reg = cra_pkg::RX_SIZE_RESET;
        errors   = 0;
    endfunction

    function void set_size(logic [cra_pkg::SIZE_W-1:0] v);
        size_reg = v;
    endfunction

    function int active_count();
        return (int'(size_reg) > cra_pkg::TABLE_ENTRIES) ? cra_pkg::TABLE_ENTRIES
                                                         : int'(size_reg);
    endfunction

    function bit entry_accepts(int k, logic [cra_pkg::WORD_W-1:0] w);
        return ((w ^ ident_tab[k]) & mask_tab[k]) == '0;
    endfunction

    // work out the result of an accepted beat and update the table
    function void note_beat(t_rx_beat b);
        t_rx_result r;
        int         n;
        int         hit;
        int         k;
        bit         found;
        n           = active_count();
        hit         = 0;
        found       = 1'b0;
        r.status    = cra_pkg::ST_NOMATCH;
        r.delivered = 1'b0;
        r.entry     = '0;
        r.dlc       = '0;
        r.data      = '0;
        if (b.op == cra_pkg::OP_CONFIG) begin
            if (int'(b.index) < n) begin
                ident_tab[b.index] = (cra_pkg::WORD_W'(b.ident) << cra_pkg::ID_SHIFT)
                                     | (b.rtr ? cra_pkg::BIT_RTR : '0);
                mask_tab[b.index]  = (cra_pkg::WORD_W'(b.mask) << cra_pkg::ID_SHIFT)
                                     | cra_pkg::BIT_RTR | cra_pkg::BIT_IDE;
                used_tab[b.index]  = 1'b1;
                r.status = cra_pkg::ST_OK;
            end else begin
                r.status = cra_pkg::ST_ILLEGAL;
            end
        end else if (b.overrun) begin
            r.status = cra_pkg::ST_OVERRUN;
        end else begin
            if (n <= cra_pkg::HW_FILTERS) begin
                if (int'(b.hw_idx) < n && entry_accepts(int'(b.hw_idx), b.word)) begin
                    found = 1'b1;
                    hit   = int'(b.hw_idx);
                end
            end else begin
                for (k = 0; k < n; k++) begin
                    if (!found && entry_accepts(k, b.word)) begin
                        found = 1'b1;
                        hit   = k;
                    end
                end
            end
            if (found && used_tab[hit]) begin
                r.status    = cra_pkg::ST_OK;
                r.delivered = 1'b1;
                r.entry     = cra_pkg::IDX_W'(hit);
                r.dlc       = b.dlc;
                r.data      = b.data;
            end
        end
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [cra_pkg::DATA_W-1:0] want,
                                logic [cra_pkg::DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_result(logic [1:0] st, logic dl, logic [cra_pkg::IDX_W-1:0] ent,
                               logic [cra_pkg::DLC_W-1:0] dlc,
                               logic [cra_pkg::DATA_W-1:0] data);
        t_rx_result want;
        if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing pending, expected none, actual status %0d",
                     $time, st);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("status", cra_pkg::DATA_W'(want.status), cra_pkg::DATA_W'(st));
        compare_field("delivered", cra_pkg::DATA_W'(want.delivered), cra_pkg::DATA_W'(dl));
        compare_field("matched_entry", cra_pkg::DATA_W'(want.entry), cra_pkg::DATA_W'(ent));
        compare_field("out_dlc", cra_pkg::DATA_W'(want.dlc), cra_pkg::DATA_W'(dlc));
        compare_field("out_data", want.data, data);
    endfunction

    function void flag_leftovers();
        if (pending_results.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, pending_results.size());
            errors += pending_results.size();
        end
    endfunction
endclass

module testbench;

    // a searched frame over the full table is the slowest beat
    localparam int SETTLE    = 80;
    localparam int RUN_LIMIT = 500000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [cra_pkg::SIZE_W-1:0]    i_cfg_wr_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_opcode;
    logic [cra_pkg::IDX_W-1:0]     i_entry_index;
    logic [cra_pkg::ID_W-1:0]      i_entry_ident;
    logic [cra_pkg::ID_W-1:0]      i_entry_mask;
    logic                          i_entry_rtr;
    logic [cra_pkg::WORD_W-1:0]    i_frame_word;
    logic [cra_pkg::DLC_W-1:0]     i_frame_dlc;
    logic [cra_pkg::DATA_W-1:0]    i_frame_data;
    logic [cra_pkg::HWIDX_W-1:0]   i_hw_filter_index;
    logic                          i_rx_overrun;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [1:0]                    o_status;
    logic                          o_delivered;
    logic [cra_pkg::IDX_W-1:0]     o_matched_entry;
    logic [cra_pkg::DLC_W-1:0]     o_out_dlc;
    logic [cra_pkg::DATA_W-1:0]    o_out_data;

    rx_filter_shadow shadow;
    int              cycle_count;

    can_rx_acceptance_filter_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_entry_index     (i_entry_index),
        .i_entry_ident     (i_entry_ident),
        .i_entry_mask      (i_entry_mask),
        .i_entry_rtr       (i_entry_rtr),
        .i_frame_word      (i_frame_word),
        .i_frame_dlc       (i_frame_dlc),
        .i_frame_data      (i_frame_data),
        .i_hw_filter_index (i_hw_filter_index),
        .i_rx_overrun      (i_rx_overrun),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_delivered       (o_delivered),
        .o_matched_entry   (o_matched_entry),
        .o_out_dlc         (o_out_dlc),
        .o_out_data        (o_out_data)
    );

    // 4 time unit clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit, counted in clock cycles
    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // result side back-pressure: short runs with stalls, sometimes long clean runs
    initial begin : out_ready_gen
        int run_left;
        int stall_left;
        i_out_ready = 1'b0;
        run_left    = 0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left   = ($urandom_range(0, 11) == 0) ? $urandom_range(100, 300)
                                                               : $urandom_range(0, 6);
                    stall_left = pick_gap();
                end
            end
        end
    end

    // every result beat is checked against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            shadow.check_result(o_status, o_delivered, o_matched_entry, o_out_dlc, o_out_data);
    end

    // all fields but the opcode random, so unused bits toggle too
    function automatic t_rx_beat blank_beat();
        t_rx_beat b;
        b.op      = cra_pkg::OP_FRAME;
        b.index   = cra_pkg::IDX_W'($urandom);
        b.ident   = cra_pkg::ID_W'($urandom);
        b.mask    = cra_pkg::ID_W'($urandom);
        b.rtr     = 1'($urandom);
        b.word    = $urandom;
        b.dlc     = cra_pkg::DLC_W'($urandom);
        b.data    = {$urandom, $urandom};
        b.hw_idx  = cra_pkg::HWIDX_W'($urandom);
        b.overrun = 1'($urandom);
        return b;
    endfunction

    function automatic t_rx_beat cfg_beat(logic [cra_pkg::IDX_W-1:0] idx,
                                          logic [cra_pkg::ID_W-1:0] id,
                                          logic [cra_pkg::ID_W-1:0] m, logic rtr);
        t_rx_beat b;
        b       = blank_beat();
        b.op    = cra_pkg::OP_CONFIG;
        b.index = idx;
        b.ident = id;
        b.mask  = m;
        b.rtr   = rtr;
        return b;
    endfunction

    function automatic t_rx_beat frame_beat(logic [cra_pkg::WORD_W-1:0] w,
                                            logic [cra_pkg::DLC_W-1:0] dlc,
                                            logic [cra_pkg::DATA_W-1:0] data,
                                            logic [cra_pkg::HWIDX_W-1:0] hw, logic ovr);
        t_rx_beat b;
        b         = blank_beat();
        b.op      = cra_pkg::OP_FRAME;
        b.word    = w;
        b.dlc     = dlc;
        b.data    = data;
        b.hw_idx  = hw;
        b.overrun = ovr;
        return b;
    endfunction

    // random beat, mostly aimed at entries of the shadow table so that matches happen
    function automatic t_rx_beat random_beat();
        t_rx_beat    b;
        int          n;
        int          k;
        logic [31:0] noise;
        b = blank_beat();
        n = shadow.active_count();
        if ($urandom_range(0, 99) < 28) begin
            b.op = cra_pkg::OP_CONFIG;
            if (n > 0 && $urandom_range(0, 4) != 0)
                b.index = cra_pkg::IDX_W'($urandom_range(0, n - 1));
            case ($urandom_range(0, 3))
                0:       b.mask = '1;
                1:       b.mask = '0;
                2:       b.mask = 11'h7F0 | cra_pkg::ID_W'($urandom_range(0, 15));
                default: b.mask = cra_pkg::ID_W'($urandom);
            endcase
        end else begin
            b.op  = cra_pkg::OP_FRAME;
            k     = (n > 0) ? $urandom_range(0, n - 1) : 0;
            noise = $urandom;
            // keep the compared bits of entry k, randomize the rest
            if ($urandom_range(0, 9) < 6)
                b.word = (shadow.ident_tab[k] & shadow.mask_tab[k])
                         | (noise & ~shadow.mask_tab[k]);
            else
                b.word = noise;
            // low half zero hits entries still at reset contents
            if ($urandom_range(0, 9) == 0)
                b.word[15:0] = '0;
            if (n <= cra_pkg::HW_FILTERS && $urandom_range(0, 3) != 0)
                b.hw_idx = cra_pkg::HWIDX_W'(k);
            b.overrun = ($urandom_range(0, 11) == 0);
        end
        return b;
    endfunction

    // present one beat at the falling edge and hold it until accepted
    task automatic send_beat(input t_rx_beat b);
        @(negedge i_clk);
        i_opcode          = b.op;
        i_entry_index     = b.index;
        i_entry_ident     = b.ident;
        i_entry_mask      = b.mask;
        i_entry_rtr       = b.rtr;
        i_frame_word      = b.word;
        i_frame_dlc       = b.dlc;
        i_frame_data      = b.data;
        i_hw_filter_index = b.hw_idx;
        i_rx_overrun      = b.overrun;
        i_in_valid        = 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        shadow.note_beat(b);
    endtask

    task automatic pause_sender(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // hold the sender until every pending result is back, then let the block settle
    task automatic drain_results();
        pause_sender(1);
        while (shadow.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // rx_size only changes with the block idle
    task automatic write_rx_size(input logic [cra_pkg::SIZE_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = cra_pkg::SIZE_W'($urandom);
        shadow.set_size(v);
    endtask

    task automatic run_random(input int count);
        int burst;
        int gap;
        int hold_at;
        int i;
        burst   = 0;
        hold_at = $urandom_range(count / 4, (3 * count) / 4);
        for (i = 0; i < count; i++) begin
            // one full stop mid-phase with nothing in flight
            if (i == hold_at)
                drain_results();
            if (burst > 0) begin
                burst--;
            end else begin
                gap = pick_gap();
                if (gap > 0)
                    pause_sender(gap);
                if ($urandom_range(0, 15) == 0)
                    burst = $urandom_range(20, 60);
            end
            send_beat(random_beat());
        end
    endtask

    initial begin
        shadow            = new();
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = '0;
        i_in_valid        = 1'b0;
        i_opcode          = cra_pkg::OP_CONFIG;
        i_entry_index     = '0;
        i_entry_ident     = '0;
        i_entry_mask      = '0;
        i_entry_rtr       = 1'b0;
        i_frame_word      = '0;
        i_frame_dlc       = '0;
        i_frame_data      = '0;
        i_hw_filter_index = '0;
        i_rx_overrun      = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset size, search mode
        // zero word hits entry 0 at reset contents, not configured so no delivery
        send_beat(frame_beat(32'h0000_0000, 4'h3, 64'h0123_4567_89AB_CDEF, 8'd0, 1'b0));
        // overrun drops the frame whatever it holds
        send_beat(frame_beat('1, '1, '1, '1, 1'b1));
        // entry 0: all-ones identifier, full mask, remote frames
        send_beat(cfg_beat(5'd0, 11'h7FF, 11'h7FF, 1'b1));
        send_beat(frame_beat(32'hFFE0_0002, 4'hF, '1, 8'd0, 1'b0));
        // rtr bit differs from entry 0, entry 1 still at reset matches first
        send_beat(frame_beat(32'hFFE0_0000, 4'h8, '1, 8'd0, 1'b0));
        // last entry accepts any standard data frame
        send_beat(cfg_beat(5'd31, 11'h000, 11'h000, 1'b0));
        send_beat(frame_beat(32'h0000_1231, 4'h0, '0, 8'd31, 1'b0));
        // ide bit set, nothing takes it
        send_beat(frame_beat(32'h0000_1235, 4'h1, '1, 8'd31, 1'b0));
        // earlier configured entry wins over the catch-all
        send_beat(cfg_beat(5'd1, 11'h123, 11'h7FF, 1'b0));
        send_beat(frame_beat(32'h2460_F0F0, 4'h5, 64'hA5A5_5A5A_0F0F_F0F0, 8'd1, 1'b0));
        run_random(60);

        // size equal to the hardware filter count: index mode
        write_rx_size(cra_pkg::SIZE_W'(cra_pkg::HW_FILTERS));
        send_beat(cfg_beat(5'd14, 11'h555, 11'h7FF, 1'b0));
        send_beat(cfg_beat(5'd13, 11'h555, 11'h7FF, 1'b0));
        send_beat(frame_beat(32'hAAA0_0010, 4'h9, 64'hFFFF_0000_FFFF_0000, 8'd13, 1'b0));
        // hardware index at or past the size, and an index that points elsewhere
        send_beat(frame_beat(32'hAAA0_0010, 4'h9, 64'h1, 8'd14, 1'b0));
        send_beat(frame_beat(32'hAAA0_0010, 4'h9, 64'h2, 8'd255, 1'b0));
        send_beat(frame_beat(32'hAAA0_0010, 4'h9, 64'h3, 8'd0, 1'b0));
        run_random(60);

        // empty table: every configure is illegal, no frame matches
        write_rx_size('0);
        send_beat(cfg_beat(5'd0, 11'h000, 11'h000, 1'b0));
        send_beat(frame_beat(32'h0000_0000, 4'h2, 64'h5, 8'd0, 1'b0));
        run_random(20);

        // one past the hardware filter count: back to search mode
        write_rx_size(cra_pkg::SIZE_W'(cra_pkg::HW_FILTERS + 1));
        run_random(60);

        write_rx_size(cra_pkg::SIZE_W'(1));
        run_random(30);

        // largest register value acts as the full table
        write_rx_size('1);
        send_beat(cfg_beat(5'd31, 11'h7FF, 11'h000, 1'b1));
        send_beat(frame_beat(32'h0000_FFFE, 4'h7, 64'h7, 8'd0, 1'b0));
        run_random(60);

        write_rx_size(cra_pkg::SIZE_W'(7));
        run_random(60);

        write_rx_size(cra_pkg::SIZE_W'(33));
        run_random(60);

        write_rx_size(cra_pkg::SIZE_W'(31));
        run_random(60);

        write_rx_size(cra_pkg::SIZE_W'(32));
        run_random(60);

        // every pending result back, then a quiet tail for stray beats
        drain_results();
        shadow.flag_leftovers();
        if (shadow.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### files.f
hdl/cra_pkg.sv
hdl/cra_ctrl.sv
hdl/cra_datapath.sv
hdl/can_rx_acceptance_filter_unit.sv
dv/testbench.sv
